// ===== src/assert_macros.svh =====
// Assertion macros for the sorted list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define SLSR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define SLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/slsr_pkg.sv =====
// Types and constants for the sorted list core
package slsr_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STS_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_LEFT,
		SEL_KEY,
		SEL_RIGHT
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      occupied;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

endpackage

// ===== src/slsr_if.sv =====
// Request and response channel interfaces of the sorted list core
interface slsr_req_if;
	logic                                valid;
	logic                                ready;
	logic [slsr_pkg::OP_W-1:0]           operation;
	logic signed [slsr_pkg::VALUE_WIDTH-1:0] key_value;

	modport source (output valid, output operation, output key_value, input ready);
	modport sink   (input valid, input operation, input key_value, output ready);
endinterface

interface slsr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [slsr_pkg::STATUS_W-1:0] status;
	logic [slsr_pkg::IDX_W-1:0]    position;
	logic [slsr_pkg::CNT_W-1:0]    entry_count;

	modport source (output valid, output status, output position, output entry_count,
		input ready);
	modport sink   (input valid, input status, input position, input entry_count,
		output ready);
endinterface

// ===== src/slsr_cell.sv =====
// One cell of the sorted row: a stored value, its compare flags and its shift mux
module slsr_cell (
	input  logic                 clk,
	input  slsr_pkg::cell_ctrl_t ctrl,
	input  slsr_pkg::value_t     key,
	input  slsr_pkg::value_t     left_val,
	input  slsr_pkg::value_t     right_val,
	output slsr_pkg::value_t     val,
	output logic                 lt,
	output logic                 eq
);

	slsr_pkg::value_t val_q;
	logic             lt_q;
	logic             eq_q;

	// take a neighbour's value, the key, or hold
	always_ff @(posedge clk) begin
		case (ctrl.sel)
			slsr_pkg::SEL_LEFT:  val_q <= left_val;
			slsr_pkg::SEL_KEY:   val_q <= key;
			slsr_pkg::SEL_RIGHT: val_q <= right_val;
			default:             val_q <= val_q;
		endcase
	end

	// flags only mean something for occupied cells
	always_ff @(posedge clk) begin
		lt_q <= ctrl.occupied && (val_q < key);
		eq_q <= ctrl.occupied && (val_q == key);
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

// ===== src/sorted_list_insert_search_remove_core.sv =====
// Top level of the sorted list core: control, cell row and response register
//
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// req channel: one beat carries an operation (insert, search, remove) and a
// key; it is taken when valid and ready are both high. rsp channel: one beat
// per request with status, position and the entry count after the operation.
// Each request passes through the accepting step, a compare step in which
// every cell compares its value with the key in parallel, and an update
// step in which the position is encoded from the compare flags and the row
// shifts (right for insert, left for remove) in a single step. The response
// is registered as the update step completes; a new request is taken only
// after that, back in the idle state, so requests never overlap and the pace
// is set by the compare-then-shift pass over the row.
// The response register parts the two sides: a request is taken while an
// earlier response still waits. If the receiver stalls, the block holds in
// its update step, leaving the row unchanged until the response slot frees.
// Reset clears the entry count, the control state and the response valid;
// stored values need no clearing since only cells below the count are read.
`include "assert_macros.svh"

module sorted_list_insert_search_remove_core (
	input  logic            clk,
	input  logic            arst_n,
	slsr_req_if.sink        req,
	slsr_rsp_if.source      rsp
);

	localparam int N = slsr_pkg::CAPACITY;

	slsr_pkg::state_t                   state_q;
	slsr_pkg::state_t                   state_d;
	logic [slsr_pkg::OP_W-1:0]          op_q;
	slsr_pkg::value_t                   key_q;
	logic [slsr_pkg::CNT_W-1:0]         count_q;

	logic                               rsp_valid_q;
	logic [slsr_pkg::STATUS_W-1:0]      rsp_status_q;
	logic [slsr_pkg::IDX_W-1:0]         rsp_pos_q;
	logic [slsr_pkg::CNT_W-1:0]         rsp_count_q;

	slsr_pkg::cell_ctrl_t               ctrl [N];
	slsr_pkg::value_t                   vals [N];
	logic [N-1:0]                       lt;
	logic [N-1:0]                       eq;
	logic [N-1:0]                       occ;
	logic [N-1:0]                       first;

	logic                               req_fire;
	logic                               upd_fire;
	logic                               full;
	logic                               found;
	logic [slsr_pkg::IDX_W-1:0]         pos;
	logic                               do_insert;
	logic                               do_remove;
	logic [slsr_pkg::STATUS_W-1:0]      status_d;
	logic [slsr_pkg::IDX_W-1:0]         pos_d;
	logic [slsr_pkg::CNT_W-1:0]         count_d;

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slsr_pkg::ST_IDLE: if (req.valid) state_d = slsr_pkg::ST_CMP;
			slsr_pkg::ST_CMP:  state_d = slsr_pkg::ST_UPD;
			slsr_pkg::ST_UPD:  if (!rsp_valid_q || rsp.ready) state_d = slsr_pkg::ST_IDLE;
			default:           state_d = slsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		upd_fire  = 1'b0;
		unique case (state_q)
			slsr_pkg::ST_IDLE: req.ready = 1'b1;
			slsr_pkg::ST_CMP:  upd_fire  = 1'b0;
			slsr_pkg::ST_UPD:  upd_fire  = !rsp_valid_q || rsp.ready;
			default:           req.ready = 1'b0;
		endcase
	end

	assign req_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the request beat; it stays put until the next request
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.operation;
			key_q <= req.key_value;
		end
	end

	// ---------------------------------------------------------- flag decode
	// lt is a prefix of ones over the occupied cells; the first cell that is
	// not below the key marks the lower bound (possibly the first free cell)
	always_comb begin
		for (int i = 0; i < N; i++) begin
			occ[i] = slsr_pkg::CNT_W'(i) < count_q;
			if (i == 0) begin
				first[i] = !lt[i];
			end else begin
				first[i] = !lt[i] && lt[i-1];
			end
		end
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			if (first[i]) pos = pos | slsr_pkg::IDX_W'(i);
		end
	end

	assign full  = count_q == slsr_pkg::CNT_W'(N);
	assign found = |(first & eq & occ);

	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		status_d  = slsr_pkg::STS_DONE;
		pos_d     = '0;
		count_d   = count_q;
		case (op_q)
			slsr_pkg::OP_INSERT: begin
				if (full) begin
					status_d = slsr_pkg::STS_FULL;
				end else begin
					do_insert = 1'b1;
					pos_d     = pos;
					count_d   = count_q + 1'b1;
				end
			end
			slsr_pkg::OP_SEARCH: begin
				if (found) pos_d = pos;
				else status_d = slsr_pkg::STS_ABSENT;
			end
			slsr_pkg::OP_REMOVE: begin
				if (found) begin
					do_remove = 1'b1;
					pos_d     = pos;
					count_d   = count_q - 1'b1;
				end else begin
					status_d = slsr_pkg::STS_ABSENT;
				end
			end
			default: begin
				status_d = slsr_pkg::STS_DONE;
			end
		endcase
	end

	// ------------------------------------------------------------ cell row
	// insert: lower-bound cell takes the key, cells above take their left
	// neighbour; remove: lower-bound cell and those above take the right one
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctrl[i].occupied = occ[i];
			ctrl[i].sel      = slsr_pkg::SEL_HOLD;
			if (upd_fire && do_insert && first[i]) begin
				ctrl[i].sel = slsr_pkg::SEL_KEY;
			end else if (upd_fire && do_insert && !lt[i]) begin
				ctrl[i].sel = slsr_pkg::SEL_LEFT;
			end else if (upd_fire && do_remove && !lt[i]) begin
				ctrl[i].sel = slsr_pkg::SEL_RIGHT;
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		slsr_pkg::value_t left_val;
		slsr_pkg::value_t right_val;

		if (g == 0) begin : g_head
			assign left_val = key_q;
		end else begin : g_body
			assign left_val = vals[g-1];
		end

		if (g == N - 1) begin : g_tail
			assign right_val = vals[g];
		end else begin : g_inner
			assign right_val = vals[g+1];
		end

		slsr_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[g]),
			.key       (key_q),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (vals[g]),
			.lt        (lt[g]),
			.eq        (eq[g])
		);
	end

	// ------------------------------------------------------ count, response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd_fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			rsp_status_q <= status_d;
			rsp_pos_q    <= pos_d;
			rsp_count_q  <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.position    = rsp_pos_q;
	assign rsp.entry_count = rsp_count_q;

	// ---------------------------------------------------------- assertions
	`SLSR_ASSERT_ALWAYS(a_count_bound, count_q <= slsr_pkg::CNT_W'(N),
		"entry count above capacity")
	`SLSR_ASSERT_ALWAYS(a_first_onehot, state_q != slsr_pkg::ST_UPD || $onehot0(first),
		"lower bound not unique")
	`SLSR_ASSERT_NEXT(a_count_hold, !upd_fire, $stable(count_q),
		"entry count moved outside an update")
	`SLSR_ASSERT_NEXT(a_full_keeps, upd_fire && status_d == slsr_pkg::STS_FULL,
		count_q == slsr_pkg::CNT_W'(N), "refused insert changed the count")

endmodule

// ===== tb/slsr_result_check.sv =====
// Result checker for the sorted list core: mirrors the sorted table and compares each response
`timescale 1ns / 100ps

module slsr_result_check
	import slsr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	slsr_req_if  req,
	slsr_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    position;
		logic [CNT_W-1:0]    entry_count;
	} reply_t;

	value_t      table_vals [CAPACITY];
	int unsigned table_len;
	reply_t      owed_replies [$];

	initial begin
		table_len  = 0;
		fail_count = 0;
		pending    = 0;
	end

	// Apply one operation to the mirrored table and return the reply it owes.
	function automatic reply_t apply_to_table(input logic [OP_W-1:0] op, input value_t key);
		reply_t      res;
		int unsigned idx;
		int unsigned j;
		res.status   = STS_DONE;
		res.position = '0;
		idx          = 0;
		// first slot holding a value not below the key
		while (idx < table_len && table_vals[idx] < key)
			idx++;
		case (op)
			OP_INSERT: begin
				if (table_len >= CAPACITY) begin
					res.status = STS_FULL;
				end else begin
					for (j = table_len; j > idx; j--)
						table_vals[j] = table_vals[j-1];
					table_vals[idx] = key;
					table_len++;
					res.position = idx[IDX_W-1:0];
				end
			end
			OP_SEARCH, OP_REMOVE: begin
				if (idx < table_len && table_vals[idx] == key) begin
					res.position = idx[IDX_W-1:0];
					if (op == OP_REMOVE) begin
						for (j = idx; j + 1 < table_len; j++)
							table_vals[j] = table_vals[j+1];
						table_len--;
					end
				end else begin
					res.status = STS_ABSENT;
				end
			end
			default: ;
		endcase
		res.entry_count = table_len[CNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			// a response beat always belongs to an earlier request, so retire it first
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected response, expected none, got status %0d position %0d count %0d",
						$time, rsp.status, rsp.position, rsp.entry_count);
				end else begin
					want = owed_replies.pop_front();
					if (rsp.status !== want.status || rsp.position !== want.position ||
						rsp.entry_count !== want.entry_count) begin
						fail_count++;
						$display("%0t: mismatch, expected status %0d position %0d count %0d,",
							$time, want.status, want.position, want.entry_count);
						$display("%0t:           got status %0d position %0d count %0d",
							$time, rsp.status, rsp.position, rsp.entry_count);
					end
				end
			end
			if (req.valid && req.ready)
				owed_replies.push_back(apply_to_table(req.operation, req.key_value));
		end
		pending <= owed_replies.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the sorted list core testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
	import slsr_pkg::*;

	// operation code the core must treat as a no-op
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam value_t KEY_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam value_t KEY_MAX = ~KEY_MIN;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int HOLD_LEN        = 96;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_go;
	logic hold_done;
	int   hold_cnt;
	int   sent;
	int   fail_count;
	int   pending;

	slsr_req_if req_if ();
	slsr_rsp_if rsp_if ();

	sorted_list_insert_search_remove_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	slsr_result_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// Offer one request beat, idling first at the current sender rate, and
	// return once the beat has been taken. Valid is left high on purpose: the
	// next call either idles or replaces the payload, never both in one step.
	task automatic send_req(input logic [OP_W-1:0] op, input value_t key);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.key_value <= key;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sent++;
	endtask

	// Drop valid and hold off until every owed response has arrived. The
	// count from the checker is registered, so let it catch up before trusting it.
	task automatic wait_all_replies();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly small keys, so that searches and removes hit and duplicates pile
	// up; now and then the extremes or a fully random word.
	function automatic value_t pick_key();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return value_t'(int'($urandom_range(20)) - 10);
		else if (sel == 6)
			return $urandom_range(1) ? KEY_MAX : KEY_MIN;
		else
			return value_t'($urandom);
	endfunction

	// Bias the operation mix so the table swings between empty and full.
	function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
		int unsigned r;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				if (r < 80)      return OP_INSERT;
				else if (r < 90) return OP_SEARCH;
				else if (r < 97) return OP_REMOVE;
				else             return OP_UNUSED;
			end
			MIX_DRAIN: begin
				if (r < 75)      return OP_REMOVE;
				else if (r < 90) return OP_SEARCH;
				else if (r < 97) return OP_INSERT;
				else             return OP_UNUSED;
			end
			default: begin
				if (r < 35)      return OP_INSERT;
				else if (r < 65) return OP_SEARCH;
				else if (r < 97) return OP_REMOVE;
				else             return OP_UNUSED;
			end
		endcase
	endfunction

	// Response side: random backpressure at the current receiver rate, plus
	// one long hold-off counted here once the stimulus raises hold_go.
	initial begin
		rsp_if.ready = 1'b0;
		hold_done    = 1'b0;
		hold_cnt     = 0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				rsp_if.ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt == HOLD_LEN)
					hold_done = 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int   phase;
		int   goal;
		int   n;
		mix_t mix;

		req_if.valid     = 1'b0;
		req_if.operation = OP_INSERT;
		req_if.key_value = '0;
		hold_go          = 1'b0;
		sent             = 0;
		send_idle_pct    = 18;
		recv_idle_pct    = 73;
		arst_n           = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, extremes, duplicates, first occurrence,
		// absent keys and the unused operation code.
		send_req(OP_SEARCH, '0);                      // search on an empty table
		send_req(OP_REMOVE, value_t'(5));             // remove on an empty table
		send_req(OP_INSERT, '0);
		send_req(OP_INSERT, KEY_MAX);
		send_req(OP_INSERT, KEY_MIN);
		send_req(OP_INSERT, value_t'(-1));
		send_req(OP_INSERT, '0);                      // equal key goes before its twin
		send_req(OP_INSERT, KEY_MAX);
		send_req(OP_SEARCH, '0);                      // lowest occurrence
		send_req(OP_SEARCH, KEY_MIN);
		send_req(OP_SEARCH, KEY_MAX);
		send_req(OP_SEARCH, value_t'(1));             // absent
		send_req(OP_UNUSED, value_t'(32'h5a5a_5a5a));
		send_req(OP_REMOVE, '0);
		send_req(OP_REMOVE, '0);
		send_req(OP_REMOVE, '0);                      // gone by now
		send_req(OP_REMOVE, KEY_MIN);
		send_req(OP_REMOVE, KEY_MAX);
		send_req(OP_REMOVE, KEY_MAX);
		send_req(OP_REMOVE, value_t'(-1));            // table empty again
		send_req(OP_INSERT, value_t'(32'h5555_5555));
		send_req(OP_INSERT, value_t'(32'haaaa_aaaa));
		send_req(OP_UNUSED, value_t'(32'hffff_ffff));

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			goal = sent + ITEMS_PER_PHASE;

			if (phase == 0) begin
				// overfill once early so refused inserts and a full table are seen
				repeat (72) send_req(OP_INSERT, pick_key());
			end
			if (phase == 2) begin
				// hold the receiver off while beats keep coming, so the core
				// backs up and stalls its input; then pause until all is back
				hold_go = 1'b1;
				repeat (16) send_req(pick_op(MIX_BLEND), pick_key());
				wait_all_replies();
			end

			while (sent < goal) begin
				mix = mix_t'($urandom_range(2));
				n   = $urandom_range(16, 80);
				repeat (n) send_req(pick_op(mix), pick_key());
				if ($urandom_range(4) == 0)
					wait_all_replies();
			end
		end

		wait_all_replies();
		repeat (12) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
